@@ hw/rtl/ldm_pkg.sv @@
// Shared types and constants for the lens distortion mapper.
package ldm_pkg;

    localparam int COORD_BITS = 24;
    localparam int CENTER_W   = 2 * COORD_BITS;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int FOCAL_W    = 32;
    localparam int COEF_W     = 32;
    localparam int FRAC_N     = 28;
    localparam int WIDE_W     = 48;
    localparam int HALF_W     = WIDE_W / 2;
    localparam int PROD_W     = 2 * WIDE_W;
    localparam int SHAMT_W    = 6;
    localparam int MUL_LAT    = 4;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [WIDE_W-1:0]     t_wide;
    typedef logic [SHAMT_W-1:0]           t_shamt;

    localparam t_wide  WIDE_MAX = t_wide'((64'd1 << (WIDE_W - 1)) - 64'd1);
    localparam t_wide  ONE_Q    = t_wide'(64'd1 << FRAC_N);
    localparam t_shamt SH_NORM  = t_shamt'(12);
    localparam t_shamt SH_FRAC  = t_shamt'(FRAC_N);
    localparam t_shamt SH_DST   = t_shamt'(36);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_INV_FOCAL,
        CFG_SRC_CENTER,
        CFG_RADIAL_K1,
        CFG_RADIAL_K2,
        CFG_RADIAL_K3,
        CFG_TANGENTIAL,
        CFG_DST_FOCAL,
        CFG_DST_CENTER
    } t_cfg_idx;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        logic   last_in;
    } t_point_in;

    typedef struct packed {
        t_coord out_x;
        t_coord out_y;
        logic   last_out;
        logic   saturated;
    } t_point_out;

endpackage

@@ hw/rtl/lens_distortion_mapper.sv @@
// Radial and tangential lens distortion mapper: pixel point in, distorted pixel point out.
//
// One point is taken on every clock at which start is high; busy never rises, so a
// new point may follow in the very next cycle. Each result appears with o_valid
// for one cycle, in request order. Its path is the input register, seven dependent
// multiply steps through the multipliers (normalize, squares, r4, r6, k3 term, x*c
// with tangential terms, destination scale), three saturating-add registers and
// the output register. Registers written while points are in flight act on those
// points mid-way, so write them only when the pipeline is empty.
module lens_distortion_mapper
    import ldm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_point_in        i_point,
    output logic             o_valid,
    output t_point_out       o_result,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int OW = WIDE_W + 1;
    localparam int DW = COORD_BITS + 1;

    // Multiplier slots.
    localparam int MU_NX = 0, MU_NY = 1, MU_XX = 2, MU_YY = 3, MU_XY = 4;
    localparam int MU_R4 = 5, MU_K1 = 6, MU_R6 = 7, MU_K2 = 8, MU_K3 = 9;
    localparam int MU_XC = 10, MU_YC = 11, MU_P1A1 = 12, MU_P2A2 = 13;
    localparam int MU_P1A3 = 14, MU_P2A1 = 15, MU_OX = 16, MU_OY = 17;
    localparam int NMUL = 18;

    // Multiply steps, each with a delay line of the multiplier latency alongside.
    localparam int PH_NORM = 0, PH_SQ = 1, PH_R4 = 2, PH_R6 = 3;
    localparam int PH_K3 = 4, PH_XC = 5, PH_DST = 6;
    localparam int NPH = 7;
    localparam int LT = MUL_LAT - 1;

    localparam int PIPE_LAT = 5 + NPH * MUL_LAT;

    localparam logic signed [OW-1:0] SUM_MAX = OW'(WIDE_MAX);
    localparam logic signed [OW-1:0] SUM_MIN = -SUM_MAX;
    localparam logic signed [OW-1:0] OUT_MAX = OW'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [OW-1:0] OUT_MIN = -OUT_MAX - OW'(1);

    typedef struct packed {
        logic  sat;
        t_wide v;
    } t_sres;

    // Per-point context. From the x1/y1 stage on, x and y carry x1 and y1.
    typedef struct packed {
        logic  last;
        logic  sat;
        t_wide x;
        t_wide y;
        t_wide r2;
        t_wide a1;
        t_wide a2;
        t_wide a3;
        t_wide c;
    } t_ctx;

    function automatic t_sres f_sadd(input t_wide a, input t_wide b);
        logic signed [OW-1:0] s;
        t_sres r;
        s = OW'(a) + OW'(b);
        r.sat = 1'b0;
        r.v   = s[WIDE_W-1:0];
        if (s > SUM_MAX) begin
            r.sat = 1'b1;
            r.v   = WIDE_MAX;
        end else if (s < SUM_MIN) begin
            r.sat = 1'b1;
            r.v   = -WIDE_MAX;
        end
        return r;
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0]    r_src_inv_focal;
    logic [CENTER_W-1:0] r_src_center;
    logic [COEF_W-1:0]   r_k1, r_k2, r_k3;
    logic [CFG_W-1:0]    r_tangential;
    logic [CFG_W-1:0]    r_dst_focal;
    logic [CENTER_W-1:0] r_dst_center;

    logic [FOCAL_W-1:0]        ifx, ify, dfx, dfy;
    t_coord                    scx, scy, dcx, dcy;
    logic signed [COEF_W-1:0]  k1, k2, k3, p1, p2;

    // Pipeline state.
    logic                r_s0_v;
    t_point_in           r_s0;
    t_coord              s0_px, s0_py;
    logic signed [DW-1:0] s0_dx, s0_dy;

    t_ctx                r_line [NPH][MUL_LAT];
    logic [MUL_LAT-1:0]  r_line_v [NPH];
    t_ctx                n_head [NPH];
    logic [NPH-1:0]      n_head_v;

    t_ctx  r_c, r_g, r_i, n_c, n_g, n_i;
    logic  r_c_v, r_g_v, r_i_v;

    t_point_out n_out;

    t_wide  m_a [NMUL];
    t_wide  m_b [NMUL];
    t_shamt m_sh [NMUL];
    t_wide  m_p [NMUL];
    logic   m_sat [NMUL];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_inv_focal <= '0;
            r_src_center    <= '0;
            r_k1            <= '0;
            r_k2            <= '0;
            r_k3            <= '0;
            r_tangential    <= '0;
            r_dst_focal     <= '0;
            r_dst_center    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SRC_INV_FOCAL: r_src_inv_focal <= i_cfg_data;
                CFG_SRC_CENTER:    r_src_center    <= i_cfg_data[CENTER_W-1:0];
                CFG_RADIAL_K1:     r_k1            <= i_cfg_data[COEF_W-1:0];
                CFG_RADIAL_K2:     r_k2            <= i_cfg_data[COEF_W-1:0];
                CFG_RADIAL_K3:     r_k3            <= i_cfg_data[COEF_W-1:0];
                CFG_TANGENTIAL:    r_tangential    <= i_cfg_data;
                CFG_DST_FOCAL:     r_dst_focal     <= i_cfg_data;
                CFG_DST_CENTER:    r_dst_center    <= i_cfg_data[CENTER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign ifx = r_src_inv_focal[CFG_W-1:FOCAL_W];
    assign ify = r_src_inv_focal[FOCAL_W-1:0];
    assign scx = r_src_center[CENTER_W-1:COORD_BITS];
    assign scy = r_src_center[COORD_BITS-1:0];
    assign k1  = r_k1;
    assign k2  = r_k2;
    assign k3  = r_k3;
    assign p1  = r_tangential[CFG_W-1:COEF_W];
    assign p2  = r_tangential[COEF_W-1:0];
    assign dfx = r_dst_focal[CFG_W-1:FOCAL_W];
    assign dfy = r_dst_focal[FOCAL_W-1:0];
    assign dcx = r_dst_center[CENTER_W-1:COORD_BITS];
    assign dcy = r_dst_center[COORD_BITS-1:0];

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else begin
            r_s0_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= i_point;
    end

    assign s0_px = r_s0.point_x;
    assign s0_py = r_s0.point_y;
    assign s0_dx = DW'(s0_px) - DW'(scx);
    assign s0_dy = DW'(s0_py) - DW'(scy);

    for (genvar g = 0; g < NMUL; g++) begin : g_mul
        ldm_mulr u_mul (
            .i_clk   (i_clk),
            .i_a     (m_a[g]),
            .i_b     (m_b[g]),
            .i_shift (m_sh[g]),
            .o_p     (m_p[g]),
            .o_sat   (m_sat[g])
        );
    end

    always_comb begin
        for (int i = 0; i < NMUL; i++) begin
            m_sh[i] = SH_FRAC;
        end
        m_sh[MU_NX] = SH_NORM;
        m_sh[MU_NY] = SH_NORM;
        m_sh[MU_OX] = SH_DST;
        m_sh[MU_OY] = SH_DST;
    end

    always_comb begin
        t_sres s_x2d, s_y2d, s_r2, s_a1, s_a2, s_a3;
        t_sres s_c0, s_c1, s_c2, s_x1a, s_x1, s_y1a, s_y1;
        logic signed [OW-1:0] n_ox, n_oy;

        // Normalize: (p - center) * (1 / f).
        n_head[PH_NORM]      = '0;
        n_head[PH_NORM].last = r_s0.last_in;
        n_head_v[PH_NORM]    = r_s0_v;
        m_a[MU_NX] = t_wide'(s0_dx);
        m_b[MU_NX] = t_wide'(ifx);
        m_a[MU_NY] = t_wide'(s0_dy);
        m_b[MU_NY] = t_wide'(ify);

        // Squares and cross product.
        n_head[PH_SQ]     = r_line[PH_NORM][LT];
        n_head_v[PH_SQ]   = r_line_v[PH_NORM][LT];
        n_head[PH_SQ].x   = m_p[MU_NX];
        n_head[PH_SQ].y   = m_p[MU_NY];
        n_head[PH_SQ].sat = r_line[PH_NORM][LT].sat | m_sat[MU_NX] | m_sat[MU_NY];
        m_a[MU_XX] = n_head[PH_SQ].x;
        m_b[MU_XX] = n_head[PH_SQ].x;
        m_a[MU_YY] = n_head[PH_SQ].y;
        m_b[MU_YY] = n_head[PH_SQ].y;
        m_a[MU_XY] = n_head[PH_SQ].x;
        m_b[MU_XY] = n_head[PH_SQ].y;

        // r2 and the tangential operands.
        s_r2  = f_sadd(m_p[MU_XX], m_p[MU_YY]);
        s_a1  = f_sadd(m_p[MU_XY], m_p[MU_XY]);
        s_x2d = f_sadd(m_p[MU_XX], m_p[MU_XX]);
        s_y2d = f_sadd(m_p[MU_YY], m_p[MU_YY]);
        s_a2  = f_sadd(s_r2.v, s_x2d.v);
        s_a3  = f_sadd(s_r2.v, s_y2d.v);
        n_c     = r_line[PH_SQ][LT];
        n_c.r2  = s_r2.v;
        n_c.a1  = s_a1.v;
        n_c.a2  = s_a2.v;
        n_c.a3  = s_a3.v;
        n_c.sat = r_line[PH_SQ][LT].sat | m_sat[MU_XX] | m_sat[MU_YY] | m_sat[MU_XY]
                | s_r2.sat | s_a1.sat | s_x2d.sat | s_y2d.sat | s_a2.sat | s_a3.sat;

        // r4 and k1 * r2.
        n_head[PH_R4]   = r_c;
        n_head_v[PH_R4] = r_c_v;
        m_a[MU_R4] = r_c.r2;
        m_b[MU_R4] = r_c.r2;
        m_a[MU_K1] = t_wide'(k1);
        m_b[MU_K1] = r_c.r2;

        // r6 and k2 * r4; the radial factor starts to accumulate.
        s_c0 = f_sadd(ONE_Q, m_p[MU_K1]);
        n_head[PH_R6]     = r_line[PH_R4][LT];
        n_head_v[PH_R6]   = r_line_v[PH_R4][LT];
        n_head[PH_R6].c   = s_c0.v;
        n_head[PH_R6].sat = r_line[PH_R4][LT].sat | m_sat[MU_R4] | m_sat[MU_K1] | s_c0.sat;
        m_a[MU_R6] = m_p[MU_R4];
        m_b[MU_R6] = n_head[PH_R6].r2;
        m_a[MU_K2] = t_wide'(k2);
        m_b[MU_K2] = m_p[MU_R4];

        // k3 * r6.
        s_c1 = f_sadd(r_line[PH_R6][LT].c, m_p[MU_K2]);
        n_head[PH_K3]     = r_line[PH_R6][LT];
        n_head_v[PH_K3]   = r_line_v[PH_R6][LT];
        n_head[PH_K3].c   = s_c1.v;
        n_head[PH_K3].sat = r_line[PH_R6][LT].sat | m_sat[MU_R6] | m_sat[MU_K2] | s_c1.sat;
        m_a[MU_K3] = t_wide'(k3);
        m_b[MU_K3] = m_p[MU_R6];

        // Radial factor complete.
        s_c2    = f_sadd(r_line[PH_K3][LT].c, m_p[MU_K3]);
        n_g     = r_line[PH_K3][LT];
        n_g.c   = s_c2.v;
        n_g.sat = r_line[PH_K3][LT].sat | m_sat[MU_K3] | s_c2.sat;

        // x * c, y * c and the tangential products.
        n_head[PH_XC]   = r_g;
        n_head_v[PH_XC] = r_g_v;
        m_a[MU_XC]   = r_g.x;
        m_b[MU_XC]   = r_g.c;
        m_a[MU_YC]   = r_g.y;
        m_b[MU_YC]   = r_g.c;
        m_a[MU_P1A1] = t_wide'(p1);
        m_b[MU_P1A1] = r_g.a1;
        m_a[MU_P2A2] = t_wide'(p2);
        m_b[MU_P2A2] = r_g.a2;
        m_a[MU_P1A3] = t_wide'(p1);
        m_b[MU_P1A3] = r_g.a3;
        m_a[MU_P2A1] = t_wide'(p2);
        m_b[MU_P2A1] = r_g.a1;

        // Distorted normalized point.
        s_x1a = f_sadd(m_p[MU_XC], m_p[MU_P1A1]);
        s_x1  = f_sadd(s_x1a.v, m_p[MU_P2A2]);
        s_y1a = f_sadd(m_p[MU_YC], m_p[MU_P1A3]);
        s_y1  = f_sadd(s_y1a.v, m_p[MU_P2A1]);
        n_i     = r_line[PH_XC][LT];
        n_i.x   = s_x1.v;
        n_i.y   = s_y1.v;
        n_i.sat = r_line[PH_XC][LT].sat
                | m_sat[MU_XC] | m_sat[MU_YC] | m_sat[MU_P1A1]
                | m_sat[MU_P2A2] | m_sat[MU_P1A3] | m_sat[MU_P2A1]
                | s_x1a.sat | s_x1.sat | s_y1a.sat | s_y1.sat;

        // Destination scale.
        n_head[PH_DST]   = r_i;
        n_head_v[PH_DST] = r_i_v;
        m_a[MU_OX] = r_i.x;
        m_b[MU_OX] = t_wide'(dfx);
        m_a[MU_OY] = r_i.y;
        m_b[MU_OY] = t_wide'(dfy);

        // Destination offset and clip to the coordinate range.
        n_ox = OW'(m_p[MU_OX]) + OW'(dcx);
        n_oy = OW'(m_p[MU_OY]) + OW'(dcy);
        n_out.last_out  = r_line[PH_DST][LT].last;
        n_out.saturated = r_line[PH_DST][LT].sat | m_sat[MU_OX] | m_sat[MU_OY];
        if (n_ox > OUT_MAX) begin
            n_ox = OUT_MAX;
            n_out.saturated = 1'b1;
        end else if (n_ox < OUT_MIN) begin
            n_ox = OUT_MIN;
            n_out.saturated = 1'b1;
        end
        if (n_oy > OUT_MAX) begin
            n_oy = OUT_MAX;
            n_out.saturated = 1'b1;
        end else if (n_oy < OUT_MIN) begin
            n_oy = OUT_MIN;
            n_out.saturated = 1'b1;
        end
        n_out.out_x = n_ox[COORD_BITS-1:0];
        n_out.out_y = n_oy[COORD_BITS-1:0];
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NPH; p++) begin
                r_line_v[p] <= '0;
            end
            r_c_v   <= 1'b0;
            r_g_v   <= 1'b0;
            r_i_v   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            for (int p = 0; p < NPH; p++) begin
                r_line_v[p] <= {r_line_v[p][MUL_LAT-2:0], n_head_v[p]};
            end
            r_c_v   <= r_line_v[PH_SQ][LT];
            r_g_v   <= r_line_v[PH_K3][LT];
            r_i_v   <= r_line_v[PH_XC][LT];
            o_valid <= r_line_v[PH_DST][LT];
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NPH; p++) begin
            r_line[p][0] <= n_head[p];
            for (int s = 1; s < MUL_LAT; s++) begin
                r_line[p][s] <= r_line[p][s-1];
            end
        end
        r_c      <= n_c;
        r_g      <= n_g;
        r_i      <= n_i;
        o_result <= n_out;
    end

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##PIPE_LAT o_valid)
        else $error("accepted request produced no result at the expected cycle");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, PIPE_LAT))
        else $error("result strobe without a matching request");

    a_last_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.last_out == $past(i_point.last_in, PIPE_LAT)))
        else $error("last marker does not match its request");

endmodule

@@ hw/rtl/ldm_mulr.sv @@
// Four-stage signed multiplier with round-half-away, right shift and saturation.
module ldm_mulr
    import ldm_pkg::*;
(
    input  logic   i_clk,
    input  t_wide  i_a,
    input  t_wide  i_b,
    input  t_shamt i_shift,
    output t_wide  o_p,
    output logic   o_sat
);

    logic [WIDE_W-1:0]   r_ma, r_mb;
    logic                r_neg1, r_neg2, r_neg3;
    t_shamt              r_sh1, r_sh2, r_sh3;
    logic [2*HALF_W-1:0] r_ll, r_lh, r_hl, r_hh;
    logic [PROD_W-1:0]   r_prod;

    logic [PROD_W-1:0]   n_prod;
    logic [PROD_W-1:0]   q;
    logic                ovf;
    logic [WIDE_W-1:0]   mag;

    // Stage 1: magnitudes and result sign.
    always_ff @(posedge i_clk) begin
        r_ma   <= i_a[WIDE_W-1] ? WIDE_W'(-i_a) : WIDE_W'(i_a);
        r_mb   <= i_b[WIDE_W-1] ? WIDE_W'(-i_b) : WIDE_W'(i_b);
        r_neg1 <= i_a[WIDE_W-1] ^ i_b[WIDE_W-1];
        r_sh1  <= i_shift;
    end

    // Stage 2: four half-width partial products.
    always_ff @(posedge i_clk) begin
        r_ll   <= r_ma[HALF_W-1:0] * r_mb[HALF_W-1:0];
        r_lh   <= r_ma[HALF_W-1:0] * r_mb[WIDE_W-1:HALF_W];
        r_hl   <= r_ma[WIDE_W-1:HALF_W] * r_mb[HALF_W-1:0];
        r_hh   <= r_ma[WIDE_W-1:HALF_W] * r_mb[WIDE_W-1:HALF_W];
        r_neg2 <= r_neg1;
        r_sh2  <= r_sh1;
    end

    // Stage 3: sum of partial products with the rounding half added in.
    always_comb begin
        n_prod = {r_hh, r_ll}
               + (PROD_W'(r_lh) << HALF_W)
               + (PROD_W'(r_hl) << HALF_W)
               + (PROD_W'(1) << (r_sh2 - t_shamt'(1)));
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_neg3 <= r_neg2;
        r_sh3  <= r_sh2;
    end

    // Stage 4: scale, clip to the wide range and restore the sign.
    always_comb begin
        q   = r_prod >> r_sh3;
        ovf = |q[PROD_W-1:WIDE_W-1];
        mag = ovf ? WIDE_W'(WIDE_MAX) : q[WIDE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        o_p   <= r_neg3 ? t_wide'(-mag) : t_wide'(mag);
        o_sat <= ovf;
    end

endmodule
